// File: sv/nearest_palette_color_lab_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest palette colour block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_LAB_MACROS_SVH
`define NEAREST_PALETTE_COLOR_LAB_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every rising edge outside reset
`define NPL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every rising edge, reset included
`define NPL_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPL_ASSERT(lbl, clk, rstn, prop, msg)
`define NPL_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

// File: sv/nplab_pkg.sv
// ---------------------------------------------------------------------------
// nplab_pkg
// Types, widths and weights for the nearest palette colour search.
// ---------------------------------------------------------------------------
package nplab_pkg;

    // default palette depth
    localparam int PALETTE_DEPTH_DEF = 64;

    // field widths
    localparam int CHAN_W  = 8;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    // distance arithmetic widths
    localparam int SQ_W      = 2 * CHAN_W;   // one squared channel difference
    localparam int SQSUM_W   = SQ_W + 1;     // da^2 + db^2
    localparam int TERM_L_W  = 30;           // 10000 * dL^2
    localparam int TERM_AB_W = 33;           // 65025 * (da^2 + db^2)
    localparam int DIST_W    = 34;           // sum of both terms

    // weights: (100*dL)^2 = 10000*dL^2, and 255^2 on the chroma channels
    localparam logic [13:0] L_WEIGHT  = 14'd10000;
    localparam logic [15:0] AB_WEIGHT = 16'd65025;

    // one Lab colour as stored in the palette
    typedef struct packed {
        logic [CHAN_W-1:0] l;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
    } lab_t;

    // absolute difference of two channel values
    function automatic logic [CHAN_W-1:0] abs_diff(
        input logic [CHAN_W-1:0] x,
        input logic [CHAN_W-1:0] y
    );
        logic [CHAN_W-1:0] d;
        if (x >= y) begin
            d = x - y;
        end else begin
            d = y - x;
        end
        return d;
    endfunction

endpackage

// File: sv/nearest_palette_color_lab.sv
// ---------------------------------------------------------------------------
// nearest_palette_color_lab
// Nearest palette colour search in 8-bit Lab space, CIE76 distance.
// ---------------------------------------------------------------------------
// A write request (action 0) stores one palette entry. A pixel request
// (action 1) walks entries 0..count-1 through the single read port of the
// palette memory, one entry per cycle, into a four-stage distance pipeline,
// and occupies the block until its result is loaded into the output
// register; the next request is taken after that, even while the result
// still waits in the output register. Count is palette_count with zero read
// as one and values above the depth read as the depth. The distance
// (100*dL)^2 + 65025*(da^2 + db^2) is compared exactly; on equal distance
// the later entry wins. Entries must be written before they are searched.
// palette_count is written only while the block is idle.
// ---------------------------------------------------------------------------
`include "nearest_palette_color_lab_macros.svh"

module nearest_palette_color_lab
    import nplab_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,

    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [SLOT_W-1:0]  entry_index,
    input  logic [CHAN_W-1:0]  lightness,
    input  logic [CHAN_W-1:0]  green_red,
    input  logic [CHAN_W-1:0]  blue_yellow,

    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAN_W-1:0]  match_lightness,
    output logic [CHAN_W-1:0]  match_green_red,
    output logic [CHAN_W-1:0]  match_blue_yellow,
    output logic [SLOT_W-1:0]  match_index
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // controller states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;

    logic [COUNT_W-1:0] palette_count_reg;
    logic [IDX_W-1:0]   last_addr_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    lab_t               pix_reg;

    logic               in_accept;
    logic               pix_start;
    logic               mem_we;
    logic               mem_re;
    logic [CMP_W-1:0]   slot_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   eff_cnt;
    logic [CMP_W-1:0]   last_ext;
    lab_t               in_colour;

    // palette memory and its registered read port
    lab_t               palette_mem [PALETTE_DEPTH];
    lab_t               rd_data_reg;

    // distance pipeline
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_last_reg;

    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               s2_last_reg;
    lab_t               s2_col_reg;
    logic [CHAN_W-1:0]  s2_dl_reg;
    logic [CHAN_W-1:0]  s2_da_reg;
    logic [CHAN_W-1:0]  s2_db_reg;

    logic               s3_valid_reg;
    logic [IDX_W-1:0]   s3_idx_reg;
    logic               s3_last_reg;
    lab_t               s3_col_reg;
    logic [SQ_W-1:0]    s3_sql_reg;
    logic [SQ_W-1:0]    s3_sqa_reg;
    logic [SQ_W-1:0]    s3_sqb_reg;

    logic               s4_valid_reg;
    logic [IDX_W-1:0]   s4_idx_reg;
    logic               s4_last_reg;
    lab_t               s4_col_reg;
    logic [TERM_L_W-1:0]  s4_term_l_reg;
    logic [TERM_AB_W-1:0] s4_term_ab_reg;

    logic [SQSUM_W-1:0] sq_ab_sum;
    logic [DIST_W-1:0]  dist_sum;
    logic               take_entry;

    // running best
    logic [DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    lab_t               best_col_reg;
    logic               done_reg;
    logic [CMP_W-1:0]   best_idx_ext;

    logic               out_valid_reg;
    logic               out_free;
    logic               out_load;

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign pix_start = in_accept && action;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_FLUSH) && done_reg && out_free;

    assign in_colour = '{l: lightness, a: green_red, b: blue_yellow};

    // writes beyond the depth are dropped; no write can meet a search read
    assign slot_ext = CMP_W'(entry_index);
    assign mem_we   = in_accept && !action && (slot_ext < CMP_W'(PALETTE_DEPTH));
    assign mem_re   = (state_reg == ST_READ);

    // effective count: zero reads as one, saturate at the depth
    assign cnt_ext = CMP_W'(palette_count_reg);
    always_comb
    begin
        priority if (cnt_ext == '0)
        begin
            eff_cnt = CMP_W'(1);
        end
        else if (cnt_ext > CMP_W'(PALETTE_DEPTH))
        begin
            eff_cnt = CMP_W'(PALETTE_DEPTH);
        end
        else
        begin
            eff_cnt = cnt_ext;
        end
    end
    assign last_ext = eff_cnt - CMP_W'(1);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            palette_count_reg <= cfg_data;
        end
    end

    // controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_addr_reg == last_addr_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller registers and read address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_addr_reg   <= '0;
            last_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pix_start)
            begin
                rd_addr_reg   <= '0;
                last_addr_reg <= last_ext[IDX_W-1:0];
            end
            else if (mem_re && (rd_addr_reg != last_addr_reg))
            begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end
        end
    end

    // pixel under search
    always_ff @(posedge clk)
    begin
        if (pix_start)
        begin
            pix_reg <= in_colour;
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[slot_ext[IDX_W-1:0]] <= in_colour;
        end
        if (mem_re)
        begin
            rd_data_reg <= palette_mem[rd_addr_reg];
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mem_re;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1 tags travel alongside the memory read
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_addr_reg;
        s1_last_reg <= (rd_addr_reg == last_addr_reg);
    end

    // stage 2: channel differences
    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        s2_col_reg  <= rd_data_reg;
        s2_dl_reg   <= abs_diff(pix_reg.l, rd_data_reg.l);
        s2_da_reg   <= abs_diff(pix_reg.a, rd_data_reg.a);
        s2_db_reg   <= abs_diff(pix_reg.b, rd_data_reg.b);
    end

    // stage 3: squares
    always_ff @(posedge clk)
    begin
        s3_idx_reg  <= s2_idx_reg;
        s3_last_reg <= s2_last_reg;
        s3_col_reg  <= s2_col_reg;
        s3_sql_reg  <= SQ_W'(s2_dl_reg) * SQ_W'(s2_dl_reg);
        s3_sqa_reg  <= SQ_W'(s2_da_reg) * SQ_W'(s2_da_reg);
        s3_sqb_reg  <= SQ_W'(s2_db_reg) * SQ_W'(s2_db_reg);
    end

    // stage 4: weighted terms
    assign sq_ab_sum = SQSUM_W'(s3_sqa_reg) + SQSUM_W'(s3_sqb_reg);

    always_ff @(posedge clk)
    begin
        s4_idx_reg     <= s3_idx_reg;
        s4_last_reg    <= s3_last_reg;
        s4_col_reg     <= s3_col_reg;
        s4_term_l_reg  <= TERM_L_W'(s3_sql_reg) * TERM_L_W'(L_WEIGHT);
        s4_term_ab_reg <= TERM_AB_W'(sq_ab_sum) * TERM_AB_W'(AB_WEIGHT);
    end

    // stage 5: distance and running best, later entry wins a tie
    assign dist_sum   = DIST_W'(s4_term_l_reg) + DIST_W'(s4_term_ab_reg);
    assign take_entry = s4_valid_reg && ((s4_idx_reg == '0) || (dist_sum <= best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take_entry)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= s4_idx_reg;
            best_col_reg  <= s4_col_reg;
        end
    end

    // search finished, result waits for the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (s4_valid_reg && s4_last_reg)
        begin
            done_reg <= 1'b1;
        end
        else if (out_load)
        begin
            done_reg <= 1'b0;
        end
    end

    // output register
    assign best_idx_ext = CMP_W'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            match_lightness   <= best_col_reg.l;
            match_green_red   <= best_col_reg.a;
            match_blue_yellow <= best_col_reg.b;
            match_index       <= best_idx_ext[SLOT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `NPL_ASSERT(a_start_at_zero, clk, rst_n, pix_start |=> (state_reg == ST_READ) && (rd_addr_reg == '0), "pixel request did not start reading at entry zero")
    `NPL_ASSERT(a_no_write_in_search, clk, rst_n, mem_we |-> !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !s4_valid_reg && !done_reg, "palette write while a search is in flight")
    `NPL_ASSERT(a_done_in_flush, clk, rst_n, done_reg |-> (state_reg == ST_FLUSH), "search result pending outside flush")
    `NPL_ASSERT(a_result_from_flush, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_FLUSH), "result presented without a finished search")
    `NPL_ASSERT_ANY(a_addr_in_range, clk, (state_reg == ST_READ) |-> (rd_addr_reg <= last_addr_reg), "read address ran past the last entry")

endmodule
